// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file rsb_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: check failed");

// Check that cons follows ant in the next cycle.
`define CHK_NEXT(label, clk, rst_n, ant, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ===== sv/rsb_pkg.sv =====
package rsb_pkg;

	localparam int N           = 16;
	localparam int DATA_W      = 32;
	localparam int VALUE_W     = 32;
	localparam int SRC_W       = 6;
	localparam int IDX_W       = $clog2(N);
	localparam int CNT_W       = $clog2(N + 1);
	localparam int IN_TDATA_W  = ((VALUE_W + 7) / 8) * 8;
	localparam int OUT_PAY_W   = VALUE_W + SRC_W;
	localparam int OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8;

endpackage

// ===== sv/rsb_ram.sv =====
module rsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/rsb_order.sv =====
// Sorted-order list: entry k holds the arrival index of the value of rank k.
module rsb_order (
	input  logic                     clk,
	input  logic                     ins_en,
	input  logic [rsb_pkg::IDX_W-1:0] ins_pos,
	input  logic [rsb_pkg::IDX_W-1:0] ins_idx,
	input  logic [rsb_pkg::IDX_W-1:0] rd_pos,
	output logic [rsb_pkg::IDX_W-1:0] rd_idx
);

	logic [rsb_pkg::IDX_W-1:0] ord_q [rsb_pkg::N];

	// Open a gap at the new rank: everything above it moves up one place.
	always_ff @(posedge clk) begin
		if (ins_en) begin
			for (int k = 0; k < rsb_pkg::N; k++) begin
				if (rsb_pkg::IDX_W'(k) == ins_pos) begin
					ord_q[k] <= ins_idx;
				end else if (k > 0 && rsb_pkg::IDX_W'(k) > ins_pos) begin
					ord_q[k] <= ord_q[(k > 0) ? k - 1 : 0];
				end
			end
		end
	end

	assign rd_idx = ord_q[rd_pos];

endmodule

// ===== sv/rank_sort_batch_core.sv =====
// Batch rank sort.
// Input stream (s_*): one signed value per word in s_tdata; s_tlast marks
// the final word of a batch. Up to 16 values are kept per batch; further
// words are dropped and the batch is marked truncated.
// Each accepted word is compared with the values already stored, one per
// cycle on a single comparator, and s_tready stays low from acceptance
// until the word is inserted (the first word goes straight to insertion; a
// word dropped from a full batch without s_tlast leaves s_tready high).
// On the word with s_tlast the batch streams out on m_* in ascending order,
// equal values in arrival order: m_tdata carries the value and its arrival
// index, m_tlast the final word of the batch, m_tuser the truncated flag.
// Each output word is read in ST_RD and then presented in ST_OUT; the
// output word holds steady while stalled, and no input is taken during the
// output burst. After the last output word a new empty batch begins.
// Reset (arst_n low) empties the batch and clears the truncated flag.
module rank_sort_batch_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [rsb_pkg::IN_TDATA_W-1:0]  s_tdata,  // [31:0] value
	input  logic                           s_tlast,  // last
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [rsb_pkg::OUT_TDATA_W-1:0] m_tdata,  // [31:0] sorted_value, [37:32] source_index
	output logic                           m_tlast,  // last_of_run
	output logic                           m_tuser   // truncated
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_DRAIN,
		ST_INS,
		ST_RD,
		ST_OUT
	} state_t;

	state_t                      state_q;
	logic [rsb_pkg::DATA_W-1:0]  v_q;
	logic                        last_q;
	logic [rsb_pkg::CNT_W-1:0]   fill_q;
	logic                        ovf_q;
	logic [rsb_pkg::IDX_W-1:0]   idx_q;
	logic [rsb_pkg::IDX_W-1:0]   rank_q;
	logic                        pend_s1;
	logic [rsb_pkg::IDX_W-1:0]   slot_q;
	logic                        m_tvalid_q;
	logic                        m_tlast_q;

	logic                        ram_we;
	logic                        ram_re;
	logic [rsb_pkg::IDX_W-1:0]   ram_raddr;
	logic [rsb_pkg::DATA_W-1:0]  ram_rdata;
	logic [rsb_pkg::IDX_W-1:0]   ord_idx;
	logic                        le_hit;
	logic                        in_fire;
	logic [rsb_pkg::CNT_W-1:0]   fill_m1;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign ram_we    = (state_q == ST_INS);
	assign ram_re    = (state_q == ST_CMP) || (state_q == ST_RD);
	assign ram_raddr = (state_q == ST_CMP) ? idx_q : ord_idx;
	assign le_hit    = $signed(ram_rdata) <= $signed(v_q);
	assign fill_m1   = fill_q - rsb_pkg::CNT_W'(1);

	rsb_ram #(
		.WIDTH(rsb_pkg::DATA_W),
		.DEPTH(rsb_pkg::N)
	) u_value_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_q[rsb_pkg::IDX_W-1:0]),
		.wdata(v_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	rsb_order u_order (
		.clk    (clk),
		.ins_en (ram_we),
		.ins_pos(rank_q),
		.ins_idx(fill_q[rsb_pkg::IDX_W-1:0]),
		.rd_pos (slot_q),
		.rd_idx (ord_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			ovf_q      <= 1'b0;
			pend_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
			idx_q      <= '0;
			rank_q     <= '0;
			slot_q     <= '0;
			last_q     <= 1'b0;
			v_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						v_q     <= rsb_pkg::DATA_W'(s_tdata[rsb_pkg::VALUE_W-1:0]);
						last_q  <= s_tlast;
						idx_q   <= '0;
						rank_q  <= '0;
						slot_q  <= '0;
						pend_s1 <= 1'b0;
						if (fill_q == rsb_pkg::CNT_W'(rsb_pkg::N)) begin
							// full: drop the word, still close the batch on last
							ovf_q   <= 1'b1;
							state_q <= s_tlast ? ST_RD : ST_IDLE;
						end else if (fill_q == '0) begin
							state_q <= ST_INS;
						end else begin
							state_q <= ST_CMP;
						end
					end
				end
				ST_CMP: begin
					pend_s1 <= 1'b1;
					idx_q   <= idx_q + rsb_pkg::IDX_W'(1);
					if (pend_s1 && le_hit) begin
						rank_q <= rank_q + rsb_pkg::IDX_W'(1);
					end
					if (rsb_pkg::CNT_W'(idx_q) == fill_m1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					pend_s1 <= 1'b0;
					if (le_hit) begin
						rank_q <= rank_q + rsb_pkg::IDX_W'(1);
					end
					state_q <= ST_INS;
				end
				ST_INS: begin
					fill_q  <= fill_q + rsb_pkg::CNT_W'(1);
					state_q <= last_q ? ST_RD : ST_IDLE;
				end
				ST_RD: begin
					m_tvalid_q <= 1'b1;
					m_tlast_q  <= (rsb_pkg::CNT_W'(slot_q) == fill_m1);
					state_q    <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (m_tlast_q) begin
							fill_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							slot_q  <= slot_q + rsb_pkg::IDX_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = ovf_q;
	assign m_tdata  = rsb_pkg::OUT_TDATA_W'({rsb_pkg::SRC_W'(ord_idx),
		rsb_pkg::VALUE_W'($signed(ram_rdata))});

endmodule

// ===== sv/rsb_checker.sv =====
`include "assert_macros.svh"

module rsb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [rsb_pkg::IN_TDATA_W-1:0]  s_tdata,
	input logic                           s_tlast,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [rsb_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                           m_tlast,
	input logic                           m_tuser
);

	logic in_fire;
	logic out_fire;
	logic out_stall;

	assign in_fire   = s_tvalid && s_tready;
	assign out_fire  = m_tvalid && m_tready;
	assign out_stall = m_tvalid && !m_tready;

	`CHK_NEXT(a_stall_hold, clk, arst_n, out_stall,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
	`CHK_ALWAYS(a_no_overlap, clk, arst_n, !(s_tready && m_tvalid))
	`CHK_NEXT(a_busy_after_last, clk, arst_n, in_fire && s_tlast, !s_tready)
	`CHK_NEXT(a_burst_ends, clk, arst_n, out_fire && m_tlast, !m_tvalid && s_tready)

endmodule

bind rank_sort_batch_core rsb_checker u_rsb_checker (.*);
